@@ src/sard_pkg.sv @@
// Shared types and constants for the sorted address range decoder.
`default_nettype none
package sard_pkg;

    localparam int ADDR_W    = 64;
    localparam int TGT_W     = 3;
    localparam int OFF_W     = 32;
    localparam int S_TDATA_W = 168;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_MISS    = 2'd1,
        STAT_OVERLAP = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_CMP,
        ST_DEC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] size_m1;
        logic [TGT_W-1:0]  target;
    } entry_t;

    typedef struct packed {
        logic              compare;
        logic              insert;
        logic [ADDR_W-1:0] key;
        logic [ADDR_W-1:0] last;
        logic [ADDR_W-1:0] size_m1;
        logic [TGT_W-1:0]  target;
    } cell_cmd_t;

endpackage
`default_nettype wire

@@ src/sorted_address_range_decoder.sv @@
// Top level of the sorted address range decoder.
//
// Each address space holds a sorted table of non-overlapping ranges, each
// tagged with a target, plus one 32-bit base offset per target. An input
// transaction on s_* carries the opcode and space in s_tuser and the
// address, range last, target and target offset in s_tdata. Every input
// transaction yields exactly one result transaction on m_*: the status in
// m_tuser, the hit target and relative address in m_tdata.
// The accepting edge captures the transaction and forms the offset sums;
// the compare state compares in every cell of the slot row, the decode
// state resolves and commits (shift the row, read the offset memory),
// the output state subtracts the offset and loads the result register.
// One item is in flight at a time; the next is taken only after the
// result loads. After reset the offset memory is zeroed, one entry a
// cycle, over all 2**(space bits + target bits) entries (32 at the
// default sizes), with s_tready low. Range counts clear at once. A
// stalled receiver holds the result in the output register; the next
// item is still accepted and waits in its final step for the register.
`default_nettype none
module sorted_address_range_decoder #(
    parameter int MAX_RANGES  = 16,
    parameter int NUM_TARGETS = 8,
    parameter int NUM_SPACES  = 4
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // address, range_last, target, target_offset, zero padding
    input  wire logic [sard_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode, space
    input  wire logic [sard_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // hit_target, relative_address, zero padding
    output logic [sard_pkg::M_TDATA_W-1:0]      m_tdata,
    // status
    output logic [sard_pkg::M_TUSER_W-1:0]      m_tuser
);

    localparam int SW = (NUM_SPACES > 1) ? $clog2(NUM_SPACES) : 1;
    localparam int TW = $clog2(NUM_TARGETS);
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int AW = SW + TW;
    localparam int PAD_W = sard_pkg::M_TDATA_W - sard_pkg::ADDR_W - sard_pkg::TGT_W;

    sard_pkg::state_t state_reg, state_next;

    sard_pkg::opcode_t           op_reg;
    logic [1:0]                  sp_reg;
    logic [sard_pkg::ADDR_W-1:0] addr_reg;
    logic [sard_pkg::ADDR_W-1:0] key_reg;
    logic [sard_pkg::ADDR_W-1:0] last_reg;
    logic [sard_pkg::ADDR_W-1:0] size_m1_reg;
    logic                        bad_order_reg;
    logic [sard_pkg::TGT_W-1:0]  tg_reg;
    logic [sard_pkg::OFF_W-1:0]  off_reg;

    logic [CW-1:0] count_reg [NUM_SPACES];

    sard_pkg::status_t           status_reg;
    logic [sard_pkg::TGT_W-1:0]  hit_tgt_reg;
    logic                        rel_en_reg;
    logic                        tgt_in_reg;

    logic                        m_tvalid_reg;
    logic [sard_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [sard_pkg::M_TUSER_W-1:0] m_tuser_reg;

    logic accept, cmp_en, dec_en, out_load, clr_busy;

    logic [SW-1:0] sp_idx;
    logic [TW-1:0] tg_idx;
    logic          sp_ok, tg_ok;
    logic [CW-1:0] count_cur;
    logic          full;

    sard_pkg::cell_cmd_t cmd;
    sard_pkg::entry_t    entry_w [MAX_RANGES];
    logic                le_w    [MAX_RANGES];
    logic                valid_w [MAX_RANGES];
    logic                hold_w  [MAX_RANGES];
    logic                clash_w [MAX_RANGES];

    logic                       hit_any, clash_any;
    logic [sard_pkg::TGT_W-1:0] hit_tgt;
    logic                       commit;
    sard_pkg::status_t          status_w;

    logic                        off_wr_en, off_rd_en;
    logic [sard_pkg::OFF_W-1:0]  off_rd;
    logic [sard_pkg::ADDR_W-1:0] rel_w;

    assign sp_idx    = SW'(sp_reg);
    assign tg_idx    = TW'(tg_reg);
    assign sp_ok     = 32'(sp_reg) < NUM_SPACES;
    assign tg_ok     = 32'(tg_reg) < NUM_TARGETS;
    assign count_cur = sp_ok ? count_reg[sp_idx] : '0;
    assign full      = count_cur >= CW'(MAX_RANGES);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sard_pkg::ST_CLR:  if (!clr_busy) state_next = sard_pkg::ST_IDLE;
            sard_pkg::ST_IDLE: if (s_tvalid) state_next = sard_pkg::ST_CMP;
            sard_pkg::ST_CMP:  state_next = sard_pkg::ST_DEC;
            sard_pkg::ST_DEC:  state_next = sard_pkg::ST_OUT;
            sard_pkg::ST_OUT:  if (!m_tvalid_reg || m_tready) state_next = sard_pkg::ST_IDLE;
            default:           state_next = sard_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        cmp_en   = 1'b0;
        dec_en   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            sard_pkg::ST_CLR:  ;
            sard_pkg::ST_IDLE: s_tready = 1'b1;
            sard_pkg::ST_CMP:  cmp_en = 1'b1;
            sard_pkg::ST_DEC:  dec_en = 1'b1;
            sard_pkg::ST_OUT:  out_load = !m_tvalid_reg || m_tready;
            default:           ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sard_pkg::ST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    // capture the transaction and form the absolute range bounds
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= sard_pkg::opcode_t'(s_tuser[1:0]);
            sp_reg   <= s_tuser[3:2];
            addr_reg <= s_tdata[63:0];
            tg_reg   <= s_tdata[130:128];
            off_reg  <= s_tdata[162:131];
            last_reg <= {32'd0, s_tdata[162:131]} + s_tdata[127:64];
            if (sard_pkg::opcode_t'(s_tuser[1:0]) == sard_pkg::OP_INSERT) begin
                key_reg <= {32'd0, s_tdata[162:131]} + s_tdata[63:0];
            end else begin
                key_reg <= s_tdata[63:0];
            end
        end
        if (cmp_en) begin
            size_m1_reg   <= last_reg - key_reg;
            bad_order_reg <= last_reg < key_reg;
        end
    end

    assign cmd.compare = cmp_en;
    assign cmd.insert  = commit;
    assign cmd.key     = key_reg;
    assign cmd.last    = last_reg;
    assign cmd.size_m1 = size_m1_reg;
    assign cmd.target  = tg_reg;

    for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
        if (g == 0) begin : g_head
            sard_cell #(
                .NUM_SPACES(NUM_SPACES),
                .SW        (SW),
                .IS_FIRST  (1'b1)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cmd       (cmd),
                .space_idx (sp_idx),
                .slot_valid(CW'(g) < count_cur),
                .prev_le   (1'b1),
                .prev_valid(1'b0),
                .prev_entry('0),
                .entry     (entry_w[g]),
                .le        (le_w[g]),
                .valid     (valid_w[g]),
                .hold      (hold_w[g]),
                .clash     (clash_w[g])
            );
        end else begin : g_body
            sard_cell #(
                .NUM_SPACES(NUM_SPACES),
                .SW        (SW),
                .IS_FIRST  (1'b0)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cmd       (cmd),
                .space_idx (sp_idx),
                .slot_valid(CW'(g) < count_cur),
                .prev_le   (le_w[g-1]),
                .prev_valid(valid_w[g-1]),
                .prev_entry(entry_w[g-1]),
                .entry     (entry_w[g]),
                .le        (le_w[g]),
                .valid     (valid_w[g]),
                .hold      (hold_w[g]),
                .clash     (clash_w[g])
            );
        end
    end

    always_comb begin
        hit_any   = 1'b0;
        clash_any = 1'b0;
        hit_tgt   = '0;
        for (int i = 0; i < MAX_RANGES; i++) begin
            hit_any   = hit_any | hold_w[i];
            clash_any = clash_any | clash_w[i];
            hit_tgt   = hit_tgt | (hold_w[i] ? entry_w[i].target : '0);
        end
    end

    always_comb begin
        commit   = 1'b0;
        status_w = sard_pkg::STAT_OK;
        unique case (op_reg)
            sard_pkg::OP_LOOKUP: begin
                status_w = (sp_ok && hit_any) ? sard_pkg::STAT_OK : sard_pkg::STAT_MISS;
            end
            sard_pkg::OP_INSERT: begin
                priority if (!sp_ok || !tg_ok || bad_order_reg || hit_any || clash_any) begin
                    status_w = sard_pkg::STAT_OVERLAP;
                end else if (full) begin
                    status_w = sard_pkg::STAT_FULL;
                end else begin
                    status_w = sard_pkg::STAT_OK;
                    commit   = dec_en;
                end
            end
            sard_pkg::OP_CLEAR: status_w = sard_pkg::STAT_OK;
            sard_pkg::OP_NOP:   status_w = sard_pkg::STAT_OK;
            default:            status_w = sard_pkg::STAT_OK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SPACES; i++) begin
                count_reg[i] <= '0;
            end
        end else if (dec_en && sp_ok) begin
            if (commit) begin
                count_reg[sp_idx] <= count_cur + 1'b1;
            end else if (op_reg == sard_pkg::OP_CLEAR) begin
                count_reg[sp_idx] <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dec_en) begin
            status_reg  <= status_w;
            rel_en_reg  <= (op_reg == sard_pkg::OP_LOOKUP) && sp_ok && hit_any;
            hit_tgt_reg <= ((op_reg == sard_pkg::OP_LOOKUP) && sp_ok && hit_any) ? hit_tgt : '0;
            tgt_in_reg  <= 32'(hit_tgt) < NUM_TARGETS;
        end
    end

    assign off_wr_en = dec_en && (op_reg == sard_pkg::OP_INSERT) && sp_ok && tg_ok;
    assign off_rd_en = dec_en && (op_reg == sard_pkg::OP_LOOKUP);

    sard_offsets #(
        .AW(AW)
    ) u_offsets (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr_en  (off_wr_en),
        .wr_addr({sp_idx, tg_idx}),
        .wr_data(off_reg),
        .rd_en  (off_rd_en),
        .rd_addr({sp_idx, TW'(hit_tgt)}),
        .rd_data(off_rd),
        .busy   (clr_busy)
    );

    assign rel_w = rel_en_reg ? (tgt_in_reg ? addr_reg - {32'd0, off_rd} : addr_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {PAD_W'(0), rel_w, hit_tgt_reg};
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

@@ src/sard_cell.sv @@
// One slot of the sorted range table, holding that slot for every address space.
`default_nettype none
module sard_cell #(
    parameter int NUM_SPACES = 4,
    parameter int SW         = 2,
    parameter bit IS_FIRST   = 1'b0
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire sard_pkg::cell_cmd_t cmd,
    input  wire logic [SW-1:0]       space_idx,
    input  wire logic                slot_valid,
    input  wire logic                prev_le,
    input  wire logic                prev_valid,
    input  wire sard_pkg::entry_t    prev_entry,
    output sard_pkg::entry_t         entry,
    output logic                     le,
    output logic                     valid,
    output logic                     hold,
    output logic                     clash
);

    sard_pkg::entry_t store [NUM_SPACES];
    sard_pkg::entry_t new_entry;

    logic                        le_reg;
    logic                        hold_reg;
    logic                        last_ge_reg;
    logic                        valid_reg;
    logic                        key_ge;
    logic [sard_pkg::ADDR_W-1:0] key_diff;
    logic                        at_pos;
    logic                        shift;

    assign entry    = store[space_idx];
    assign key_ge   = entry.first <= cmd.key;
    assign key_diff = cmd.key - entry.first;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            le_reg      <= 1'b0;
            hold_reg    <= 1'b0;
            last_ge_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end else if (cmd.compare) begin
            le_reg      <= slot_valid && key_ge;
            hold_reg    <= slot_valid && key_ge && (key_diff <= entry.size_m1);
            last_ge_reg <= cmd.last >= entry.first;
            valid_reg   <= slot_valid;
        end
    end

    assign at_pos = (IS_FIRST || prev_le) && !le_reg;
    assign shift  = !IS_FIRST && prev_valid && !prev_le;

    assign new_entry.first   = cmd.key;
    assign new_entry.size_m1 = cmd.size_m1;
    assign new_entry.target  = cmd.target;

    // take the left neighbor's entry above the insert point, the new one at it
    always_ff @(posedge aclk) begin
        if (cmd.insert && (shift || at_pos)) begin
            store[space_idx] <= shift ? prev_entry : new_entry;
        end
    end

    assign le    = le_reg;
    assign valid = valid_reg;
    assign hold  = hold_reg;
    assign clash = at_pos && valid_reg && last_ge_reg;

endmodule
`default_nettype wire

@@ src/sard_offsets.sv @@
// Per-space, per-target base offset memory with a zeroing sweep after reset.
`default_nettype none
module sard_offsets #(
    parameter int AW = 5
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [sard_pkg::OFF_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [AW-1:0]              rd_addr,
    output logic [sard_pkg::OFF_W-1:0]      rd_data,
    output logic                            busy
);

    logic [sard_pkg::OFF_W-1:0] mem [2**AW];
    logic                       clr_active_reg;
    logic [AW-1:0]              clr_addr_reg;
    logic [sard_pkg::OFF_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (&clr_addr_reg) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (aresetn && clr_active_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_active_reg;

endmodule
`default_nettype wire

@@ src/sard_checker.sv @@
// Port-level checks for the sorted address range decoder, bound to its top level.
`default_nettype none
module sard_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [sard_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic [sard_pkg::S_TUSER_W-1:0] s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [sard_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [sard_pkg::M_TUSER_W-1:0] m_tuser
);

    a_stall_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_stall_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while one is in flight");

    a_fail_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != sard_pkg::STAT_OK) |-> m_tdata == '0)
        else $error("non-zero result data on a failed operation");

endmodule

bind sorted_address_range_decoder sard_checker u_sard_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
`default_nettype wire

@@ tb/sv/sorted_address_range_decoder_tb.sv @@
// Self-checking stream testbench for the sorted address range decoder.
module sorted_address_range_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sard_pkg::*;

    localparam int NSPACE = 4;
    localparam int NTGT   = 8;
    localparam int NSLOT  = 16;

    typedef struct {
        opcode_t     op;
        logic [1:0]  space;
        logic [63:0] addr;
        logic [63:0] last;
        logic [2:0]  tgt;
        logic [31:0] off;
        bit          hold;
    } bus_op_t;

    typedef struct {
        status_t     status;
        logic [2:0]  tgt;
        logic [63:0] rel;
    } answer_t;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
    } span_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // decoder tables as the block should hold them
    logic [63:0] map_first   [NSPACE][NSLOT];
    logic [63:0] map_size_m1 [NSPACE][NSLOT];
    logic [2:0]  map_tgt     [NSPACE][NSLOT];
    int unsigned map_count   [NSPACE];
    logic [31:0] map_off     [NSPACE][NTGT];

    bus_op_t     op_queue[$];
    answer_t     answer_queue[$];
    span_t       range_pool[NSPACE][$];
    logic [63:0] base [NSPACE];
    bus_op_t     in_flight;
    bit          hold_next   = 1'b0;
    int unsigned send_gap    = 0;
    int unsigned recv_stall  = 0;
    int unsigned mismatches  = 0;
    int unsigned answers_seen = 0;
    int unsigned cyc         = 0;
    logic        quiet;

    assign quiet = (cyc % 3000) < 600;

    sorted_address_range_decoder #(
        .MAX_RANGES (NSLOT),
        .NUM_TARGETS(NTGT),
        .NUM_SPACES (NSPACE)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_off();
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return 32'($urandom_range(0, 4095));
            default: return $urandom;
        endcase
    endfunction

    function automatic bit find_slot(int unsigned sp, logic [63:0] a, output int unsigned slot);
        for (int unsigned i = 0; i < map_count[sp]; i++) begin
            if (map_first[sp][i] > a) begin
                slot = i;
                return 1'b0;
            end
            if (a - map_first[sp][i] <= map_size_m1[sp][i]) begin
                slot = i;
                return 1'b1;
            end
        end
        slot = map_count[sp];
        return 1'b0;
    endfunction

    function automatic answer_t apply_op(bus_op_t r);
        answer_t     ans;
        int unsigned sp;
        int unsigned pos;
        int unsigned cnt;
        bit          hit;
        logic [63:0] lo;
        logic [63:0] hi;
        ans.status = STAT_OK;
        ans.tgt    = '0;
        ans.rel    = '0;
        sp         = r.space;
        case (r.op)
            OP_LOOKUP: begin
                hit = find_slot(sp, r.addr, pos);
                if (hit) begin
                    ans.tgt = map_tgt[sp][pos];
                    ans.rel = r.addr - {32'd0, map_off[sp][ans.tgt]};
                end else begin
                    ans.status = STAT_MISS;
                end
            end
            OP_INSERT: begin
                map_off[sp][r.tgt] = r.off;
                lo  = {32'd0, r.off} + r.addr;
                hi  = {32'd0, r.off} + r.last;
                cnt = map_count[sp];
                hit = find_slot(sp, lo, pos);
                if (hi < lo || hit) begin
                    ans.status = STAT_OVERLAP;
                end else if (pos < cnt && hi >= map_first[sp][pos]) begin
                    ans.status = STAT_OVERLAP;
                end else if (cnt >= NSLOT) begin
                    ans.status = STAT_FULL;
                end else begin
                    for (int unsigned i = cnt; i > pos; i--) begin
                        map_first[sp][i]   = map_first[sp][i-1];
                        map_size_m1[sp][i] = map_size_m1[sp][i-1];
                        map_tgt[sp][i]     = map_tgt[sp][i-1];
                    end
                    map_first[sp][pos]   = lo;
                    map_size_m1[sp][pos] = hi - lo;
                    map_tgt[sp][pos]     = r.tgt;
                    map_count[sp]        = cnt + 1;
                end
            end
            OP_CLEAR: begin
                map_count[sp] = 0;
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    function automatic void add_req(opcode_t op, int unsigned sp, logic [63:0] a,
                                    logic [63:0] l, logic [2:0] tg, logic [31:0] off);
        bus_op_t r;
        r.op      = op;
        r.space   = 2'(sp);
        r.addr    = a;
        r.last    = l;
        r.tgt     = tg;
        r.off     = off;
        r.hold    = hold_next;
        hold_next = 1'b0;
        op_queue.push_back(r);
    endfunction

    function automatic void add_range(int unsigned sp, logic [63:0] lo, logic [63:0] hi,
                                      logic [2:0] tg, logic [31:0] off);
        span_t s;
        add_req(OP_INSERT, sp, lo - {32'd0, off}, hi - {32'd0, off}, tg, off);
        if (hi >= lo) begin
            s.lo = lo;
            s.hi = hi;
            range_pool[sp].push_back(s);
        end
    endfunction

    function automatic void add_clear(int unsigned sp);
        add_req(OP_CLEAR, sp, rnd64(), rnd64(), 3'($urandom), $urandom);
        range_pool[sp].delete();
    endfunction

    // clear a space, then insert more disjoint ranges than it can hold
    function automatic void fill_space(int unsigned sp);
        int unsigned start;
        int unsigned idx;
        logic [63:0] lo;
        start = $urandom_range(0, 17);
        add_clear(sp);
        for (int unsigned k = 0; k < 18; k++) begin
            idx = (k * 7 + start) % 18;
            lo  = base[sp] + 64'(idx) * 64'h1000;
            add_range(sp, lo, lo + 64'($urandom_range(0, 4095)), 3'($urandom), pick_off());
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 40) begin
            $display("%0t ns result %0d mismatch: %s", $time, answers_seen, msg);
        end
        mismatches++;
    endtask

    // driver: present queued transactions, idle between them at random
    always @(posedge aclk) begin
        bus_op_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                answer_queue.push_back(apply_op(in_flight));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (op_queue.size() != 0 &&
                             !(op_queue[0].hold && answer_queue.size() != 0)) begin
                    nxt       = op_queue.pop_front();
                    in_flight = nxt;
                    s_tdata  <= {5'd0, nxt.off, nxt.tgt, nxt.last, nxt.addr};
                    s_tuser  <= {nxt.space, nxt.op};
                    s_tvalid <= 1'b1;
                    send_gap  = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result transaction, stall the result channel at random
    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (answer_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, status %0d", m_tuser));
                end else begin
                    want = answer_queue.pop_front();
                    if (m_tuser !== want.status) begin
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  m_tuser, want.status));
                    end
                    if (m_tdata[2:0] !== want.tgt) begin
                        report_mismatch($sformatf("hit_target %0d, want %0d",
                                                  m_tdata[2:0], want.tgt));
                    end
                    if (m_tdata[66:3] !== want.rel) begin
                        report_mismatch($sformatf("relative_address %h, want %h",
                                                  m_tdata[66:3], want.rel));
                    end
                end
                answers_seen++;
            end
            if (recv_stall != 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready  <= 1'b1;
                recv_stall = pick_gap();
            end
        end
    end

    initial begin
        int unsigned sp;
        int unsigned pick;
        logic [63:0] a;
        logic [63:0] lo;
        logic [63:0] hi;
        span_t       rng;

        for (int unsigned s = 0; s < NSPACE; s++) begin
            map_count[s] = 0;
            for (int unsigned t = 0; t < NTGT; t++) begin
                map_off[s][t] = '0;
            end
            for (int unsigned i = 0; i < NSLOT; i++) begin
                map_first[s][i]   = '0;
                map_size_m1[s][i] = '0;
                map_tgt[s][i]     = '0;
            end
        end
        base[0] = 64'd0;
        base[1] = rnd64();
        base[2] = 64'hFFFF_FFFF_FFFF_0000;
        base[3] = {$urandom, 32'd0};

        // directed: empty table, hits at range edges, each kind of overlap rejection
        add_req(OP_LOOKUP, 0, 64'h1000, '0, '0, '0);
        add_req(OP_INSERT, 0, 64'h1000, 64'h1FFF, 3'd1, 32'd0);
        add_req(OP_INSERT, 0, 64'h3000, 64'h3FFF, 3'd2, 32'h100);
        add_req(OP_LOOKUP, 0, 64'h1000, '0, '0, '0);
        add_req(OP_LOOKUP, 0, 64'h40FF, '0, '0, '0);
        add_req(OP_LOOKUP, 0, 64'h4100, '0, '0, '0);
        add_req(OP_LOOKUP, 0, 64'h0FFF, '0, '0, '0);
        add_req(OP_INSERT, 0, 64'h1800, 64'h2800, 3'd3, 32'd0);
        add_req(OP_INSERT, 0, 64'h2000, 64'h3000, 3'd4, 32'h100);
        add_req(OP_INSERT, 0, 64'h5000, 64'h4FFF, 3'd5, 32'h55);
        add_req(OP_INSERT, 0, 64'h0, '1, 3'd6, 32'h1);
        add_req(OP_INSERT, 0, 64'h9000, 64'h8000, 3'd1, 32'hFFFF_FFFF);
        add_req(OP_LOOKUP, 0, 64'h1000, '0, '0, '0);
        add_req(OP_INSERT, 3, '1, '1, 3'd7, 32'd0);
        add_req(OP_LOOKUP, 3, '1, '0, '0, '0);
        add_req(OP_INSERT, 3, 64'h0, 64'h0, 3'd0, 32'hFFFF_FFFF);
        add_req(OP_LOOKUP, 3, 64'hFFFF_FFFF, '0, '0, '0);
        add_req(OP_LOOKUP, 3, 64'h0, '1, 3'd7, '1);
        add_req(OP_LOOKUP, 1, 64'h1000, '0, '0, '0);
        add_req(OP_NOP, 2, '1, '1, 3'd7, '1);
        add_req(OP_CLEAR, 0, '0, '0, '0, '0);
        add_req(OP_LOOKUP, 0, 64'h3100, '0, '0, '0);

        // random: fill bursts, inserts in a per-space window, lookups on known ranges
        hold_next = 1'b1;
        fill_space(2);
        while (op_queue.size() < 1470) begin
            sp   = $urandom_range(0, NSPACE - 1);
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 199) == 0) begin
                hold_next = 1'b1;
            end
            if (pick == 0) begin
                fill_space(sp);
            end else if (pick < 47) begin
                if (range_pool[sp].size() != 0 && $urandom_range(0, 3) != 0) begin
                    rng = range_pool[sp][$urandom_range(0, range_pool[sp].size() - 1)];
                    case ($urandom_range(0, 4))
                        0:       a = rng.lo;
                        1:       a = rng.hi;
                        2:       a = rng.lo + (rng.hi - rng.lo) / 2;
                        3:       a = rng.lo - 64'd1;
                        default: a = rng.hi + 64'd1;
                    endcase
                end else if ($urandom_range(0, 1) == 0) begin
                    a = base[sp] + 64'($urandom_range(0, 65535));
                end else begin
                    a = rnd64();
                end
                add_req(OP_LOOKUP, sp, a, rnd64(), 3'($urandom), $urandom);
            end else if (pick < 90) begin
                if ($urandom_range(0, 9) == 0) begin
                    add_req(OP_INSERT, sp, rnd64(), rnd64(), 3'($urandom), $urandom);
                end else begin
                    lo = base[sp] + 64'($urandom_range(0, 255)) * 64'h100;
                    if ($urandom_range(0, 7) == 0) begin
                        hi = lo + (64'($urandom) << $urandom_range(0, 32));
                    end else begin
                        hi = lo + 64'($urandom_range(0, 511));
                    end
                    add_range(sp, lo, hi, 3'($urandom), pick_off());
                end
            end else if (pick < 93) begin
                add_clear(sp);
            end else begin
                add_req(OP_NOP, sp, rnd64(), rnd64(), 3'($urandom), $urandom);
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        do begin
            @(posedge aclk);
        end while (op_queue.size() != 0 || s_tvalid || answer_queue.size() != 0);
        repeat (24) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #15ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
